// ===== rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared widths, codes and controller/datapath handoff types for the
// frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 32;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned NCP_W    = 9;   // next code position, wraps at 512
  localparam int unsigned MIN_LEN  = 3;   // code byte plus two address bytes

  localparam logic [STATUS_W-1:0] STATUS_OWN   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OTHER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

  // Read address source for the decoded-byte store
  typedef enum logic [1:0] {
    RD_RX,
    RD_TX,
    RD_PAY
  } rd_sel_e;

  // Kind of result loaded into the output register
  typedef enum logic [1:0] {
    LD_BAD,
    LD_NOPL,
    LD_PAY
  } load_e;

  typedef struct packed {
    logic    byte_we;    // accepted nonzero line byte
    logic    delim;      // accepted delimiter
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    adv;        // step payload index
    logic    cap_rx;
    logic    cap_tx;
    logic    load;
    load_e   load_kind;
  } cmd_t;

  typedef struct packed {
    logic is_delim;
    logic bad;
    logic no_pl;
    logic last_pl;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/cfr_intf.sv =====
// ----------------------------------------------------------------------------
// cfr_intf
// Valid/ready channels of the frame receiver: configuration, line bytes and
// results.
// ----------------------------------------------------------------------------
interface cfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cfr_pkg::BYTE_W-1:0]   own_address;

  modport source (output valid, output own_address, input ready);
  modport sink   (input valid, input own_address, output ready);
endinterface

interface cfr_byte_if;
  logic                         valid;
  logic                         ready;
  logic [cfr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if;
  logic                         valid;
  logic                         ready;
  logic [cfr_pkg::STATUS_W-1:0] status;
  logic [cfr_pkg::BYTE_W-1:0]   dst_address;
  logic [cfr_pkg::BYTE_W-1:0]   src_address;
  logic                         has_payload;
  logic [cfr_pkg::BYTE_W-1:0]   payload_byte;
  logic [cfr_pkg::IDX_W-1:0]    payload_index;
  logic                         last;

  modport source (
    output valid, output status, output dst_address, output src_address,
    output has_payload, output payload_byte, output payload_index, output last,
    input ready
  );
  modport sink (
    input valid, input status, input dst_address, input src_address,
    input has_payload, input payload_byte, input payload_index, input last,
    output ready
  );
endinterface

// ===== rtl/cobs_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// cobs_frame_receiver
// COBS frame decoder with receiver address match.
// ----------------------------------------------------------------------------
// Line bytes come in on rx_i, one word per byte; a zero byte is the frame
// delimiter. Nonzero bytes are taken one per cycle and decoded into a local
// store of FRAME_BYTES entries. A run of FRAME_BYTES nonzero bytes drops the
// partial frame with no result. At a delimiter the frame is checked: it is
// good when the code chain lands on the delimiter and at least two bytes were
// decoded. A bad frame gives one result with status 2 and last set. A good
// frame gives one result per payload byte (status 0 when the receiver address
// matches own_address, else 1), or one result with has_payload clear when the
// payload is empty. After a delimiter the block takes no line byte until the
// frame's last result has been loaded into the output register, which a
// stall on res_o delays. The read-out is paced by the single read port of the
// decoded store, which yields one payload byte per cycle while res_o does
// not stall, once it has fetched the two address bytes. A result waiting in
// the output register does not hold off new line bytes. own_address is
// written through cfg_i at any time the block is idle and is always ready.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module cobs_frame_receiver #(
  parameter int unsigned FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfr_cfg_if.sink      cfg_i,
  cfr_byte_if.sink     rx_i,
  cfr_result_if.source res_o
);
  import cfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Register write port never stalls
  assign cfg_i.ready = 1'b1;

  cfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfr_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rx_byte_i       (rx_i.rx_byte),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_data_i      (cfg_i.own_address),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .status_o        (res_o.status),
    .dst_address_o   (res_o.dst_address),
    .src_address_o   (res_o.src_address),
    .has_payload_o   (res_o.has_payload),
    .payload_byte_o  (res_o.payload_byte),
    .payload_index_o (res_o.payload_index),
    .last_o          (res_o.last)
  );

endmodule

// ===== rtl/cfr_datapath.sv =====
// ----------------------------------------------------------------------------
// cfr_datapath
// Frame position tracking, code chain following, decoded-byte store and the
// result register.
// ----------------------------------------------------------------------------
module cfr_datapath #(
  parameter int unsigned FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfr_pkg::cmd_t                 cmd_i,
  output cfr_pkg::sts_t                 sts_o,
  input  logic [cfr_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic                          cfg_valid_i,
  input  logic [cfr_pkg::BYTE_W-1:0]    cfg_data_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [cfr_pkg::STATUS_W-1:0]  status_o,
  output logic [cfr_pkg::BYTE_W-1:0]    dst_address_o,
  output logic [cfr_pkg::BYTE_W-1:0]    src_address_o,
  output logic                          has_payload_o,
  output logic [cfr_pkg::BYTE_W-1:0]    payload_byte_o,
  output logic [cfr_pkg::IDX_W-1:0]     payload_index_o,
  output logic                          last_o
);
  import cfr_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam logic [AW:0] FB_L      = (AW+1)'(FRAME_BYTES);
  localparam logic [AW:0] MIN_LEN_L = (AW+1)'(MIN_LEN);
  // payload byte i sits in entry i+2; the final one is entry len-2
  localparam logic [AW:0] LAST_END_L = (AW+1)'(MIN_LEN + 1);

  logic [BYTE_W-1:0] mem [FRAME_BYTES];

  logic [AW-1:0]     pos_q, pos_d;
  logic [NCP_W-1:0]  ncp_q, ncp_d;
  logic [AW-1:0]     len_q;
  logic [AW-1:0]     idx_q, idx_d;
  logic [BYTE_W-1:0] own_q;
  logic [BYTE_W-1:0] rd_data_q;
  logic [BYTE_W-1:0] rx_q;
  logic [BYTE_W-1:0] tx_q;
  logic              out_valid_q;

  logic [NCP_W-1:0]  pos_ext;
  logic [AW:0]       pos_inc;
  logic              at_code;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     pay_addr;
  logic [AW:0]       idx_end;
  logic [AW+IDX_W-1:0] idx_ext;
  logic [STATUS_W-1:0] good_status;

  assign pos_ext = {{(NCP_W-AW){1'b0}}, pos_q};
  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign at_code = (pos_ext == ncp_q);
  assign wr_addr = pos_q - 1'b1;
  assign wr_data = at_code ? '0 : rx_byte_i;

  // position counter and code chain
  always_comb begin
    pos_d = pos_q;
    ncp_d = ncp_q;
    if (cmd_i.byte_we) begin
      if (pos_q == '0) begin
        ncp_d = {1'b0, rx_byte_i};
      end else if (at_code) begin
        ncp_d = pos_ext + {1'b0, rx_byte_i};
      end
      pos_d = (pos_inc == FB_L) ? '0 : pos_inc[AW-1:0];
    end else if (cmd_i.delim) begin
      pos_d = '0;
    end
  end

  assign idx_d    = cmd_i.adv ? idx_q + 1'b1 : idx_q;
  assign pay_addr = idx_d + AW'(2);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_RX:   rd_addr = '0;
      RD_TX:   rd_addr = AW'(1);
      RD_PAY:  rd_addr = pay_addr;
      default: rd_addr = '0;
    endcase
  end

  // decoded-byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_we && pos_q != '0) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ncp_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      own_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      ncp_q <= ncp_d;
      if (cmd_i.delim) begin
        len_q <= pos_q;
        idx_q <= '0;
      end else begin
        idx_q <= idx_d;
      end
      if (cfg_valid_i) begin
        own_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_rx) rx_q <= rd_data_q;
    if (cmd_i.cap_tx) tx_q <= rd_data_q;
  end

  assign idx_end     = {1'b0, idx_q} + LAST_END_L;
  assign idx_ext     = {{IDX_W{1'b0}}, idx_q};
  assign good_status = (rx_q == own_q) ? STATUS_OWN : STATUS_OTHER;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      unique case (cmd_i.load_kind)
        LD_NOPL: begin
          status_o        <= good_status;
          dst_address_o   <= rx_q;
          src_address_o   <= tx_q;
          has_payload_o   <= 1'b0;
          payload_byte_o  <= '0;
          payload_index_o <= '0;
          last_o          <= 1'b1;
        end
        LD_PAY: begin
          status_o        <= good_status;
          dst_address_o   <= rx_q;
          src_address_o   <= tx_q;
          has_payload_o   <= 1'b1;
          payload_byte_o  <= rd_data_q;
          payload_index_o <= idx_ext[IDX_W-1:0];
          last_o          <= (idx_end == {1'b0, len_q});
        end
        default: begin
          status_o        <= STATUS_BAD;
          dst_address_o   <= '0;
          src_address_o   <= '0;
          has_payload_o   <= 1'b0;
          payload_byte_o  <= '0;
          payload_index_o <= '0;
          last_o          <= 1'b1;
        end
      endcase
    end
  end

  assign res_valid_o = out_valid_q;

  assign sts_o.is_delim = (rx_byte_i == '0);
  assign sts_o.bad      = ({1'b0, pos_q} < MIN_LEN_L) || !at_code;
  assign sts_o.no_pl    = ({1'b0, len_q} == MIN_LEN_L);
  assign sts_o.last_pl  = (idx_end == {1'b0, len_q});
  assign sts_o.out_free = !out_valid_q || res_ready_i;

endmodule

// ===== rtl/cfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfr_ctrl
// Sequencer: takes line bytes, and at a delimiter reads the decoded store
// out into the result register, or for a bad frame loads a bad result.
// ----------------------------------------------------------------------------
module cfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cfr_pkg::sts_t sts_i,
  output cfr_pkg::cmd_t cmd_o
);
  import cfr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BAD  = 3'd1;
  localparam logic [2:0] S_RD0  = 3'd2;
  localparam logic [2:0] S_RD1  = 3'd3;
  localparam logic [2:0] S_RD2  = 3'd4;
  localparam logic [2:0] S_NOPL = 3'd5;
  localparam logic [2:0] S_PL   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o.byte_we   = 1'b0;
    cmd_o.delim     = 1'b0;
    cmd_o.rd_en     = 1'b0;
    cmd_o.rd_sel    = RD_RX;
    cmd_o.adv       = 1'b0;
    cmd_o.cap_rx    = 1'b0;
    cmd_o.cap_tx    = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.load_kind = LD_BAD;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (sts_i.is_delim) begin
            cmd_o.delim = 1'b1;
            state_d     = sts_i.bad ? S_BAD : S_RD0;
          end else begin
            cmd_o.byte_we = 1'b1;
          end
        end
      end
      S_BAD: begin
        if (sts_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.load_kind = LD_BAD;
          state_d         = S_IDLE;
        end
      end
      S_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_RX;
        state_d      = S_RD1;
      end
      S_RD1: begin
        cmd_o.cap_rx = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_TX;
        state_d      = S_RD2;
      end
      S_RD2: begin
        cmd_o.cap_tx = 1'b1;
        if (sts_i.no_pl) begin
          state_d = S_NOPL;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PAY;
          state_d      = S_PL;
        end
      end
      S_NOPL: begin
        if (sts_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.load_kind = LD_NOPL;
          state_d         = S_IDLE;
        end
      end
      S_PL: begin
        if (sts_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.load_kind = LD_PAY;
          if (sts_i.last_pl) begin
            state_d = S_IDLE;
          end else begin
            // fetch the next byte while this one goes out
            cmd_o.adv    = 1'b1;
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_PAY;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_needs_slot : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.load |-> sts_i.out_free
  ) else $error("result loaded over a pending result");

  a_delim_branch : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd_o.delim |=> (state_q == S_BAD || state_q == S_RD0)
  ) else $error("delimiter did not start frame check");

  a_no_write_during_read : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(cmd_o.byte_we && cmd_o.rd_en)
  ) else $error("store written during read-out");

  a_adv_with_load : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.adv |-> (cmd_o.load && !sts_i.last_pl)
  ) else $error("payload index stepped without a result");

endmodule
